// ===== rtl/spectral_color_ramp_assert.svh =====
// ----------------------------------------------------------------------------
// spectral_color_ramp_assert.svh
// Assertion macros for the color ramp block; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_COLOR_RAMP_ASSERT_SVH
`define SPECTRAL_COLOR_RAMP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked outside of reset.
`define SCR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spectral_color_ramp assertion failed");
// Checked on every edge, reset included.
`define SCR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("spectral_color_ramp assertion failed");
`else
`define SCR_ASSERT(label, clk, rst, prop)
`define SCR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg
// Ramp stops, segment reciprocals and the words passed between stages.
// ----------------------------------------------------------------------------
package scr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_STOPS = 10;
   localparam int SEG_W     = 4;
   localparam int H_W       = 18;
   localparam int COLOR_W   = 8;
   localparam int RECIP_W   = 32;
   localparam int T_W       = RECIP_W + 1;
   // offset inside one segment; the widest span is under a quarter of 1.0
   localparam int D_W       = FRAC_BITS;
   localparam int CMP_W     = (FRAC_BITS + 2 > H_W) ? FRAC_BITS + 2 : H_W;

   localparam longint ONE  = longint'(1) << FRAC_BITS;
   localparam longint FULL = longint'(1) << RECIP_W;

   // stop positions, round to nearest
   localparam longint POS [NUM_STOPS] = '{
      (  0 * ONE + 50) / 100,
      ( 12 * ONE + 50) / 100,
      ( 24 * ONE + 50) / 100,
      ( 38 * ONE + 50) / 100,
      ( 52 * ONE + 50) / 100,
      ( 66 * ONE + 50) / 100,
      ( 78 * ONE + 50) / 100,
      ( 88 * ONE + 50) / 100,
      ( 95 * ONE + 50) / 100,
      (100 * ONE + 50) / 100
   };

   // ceil(2^32 / span) of the segment that ends at each stop
   localparam logic [RECIP_W-1:0] RECIP [NUM_STOPS] = '{
      RECIP_W'(0),
      RECIP_W'((FULL + (POS[1] - POS[0]) - 1) / (POS[1] - POS[0])),
      RECIP_W'((FULL + (POS[2] - POS[1]) - 1) / (POS[2] - POS[1])),
      RECIP_W'((FULL + (POS[3] - POS[2]) - 1) / (POS[3] - POS[2])),
      RECIP_W'((FULL + (POS[4] - POS[3]) - 1) / (POS[4] - POS[3])),
      RECIP_W'((FULL + (POS[5] - POS[4]) - 1) / (POS[5] - POS[4])),
      RECIP_W'((FULL + (POS[6] - POS[5]) - 1) / (POS[6] - POS[5])),
      RECIP_W'((FULL + (POS[7] - POS[6]) - 1) / (POS[7] - POS[6])),
      RECIP_W'((FULL + (POS[8] - POS[7]) - 1) / (POS[8] - POS[7])),
      RECIP_W'((FULL + (POS[9] - POS[8]) - 1) / (POS[9] - POS[8]))
   };

   localparam logic [T_W-1:0] T_FULL = {1'b1, {RECIP_W{1'b0}}};

   localparam logic [COLOR_W-1:0] RED [NUM_STOPS] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd244, 8'd255, 8'd228, 8'd118, 8'd132, 8'd255
   };
   localparam logic [COLOR_W-1:0] GREEN [NUM_STOPS] = '{
      8'd8, 8'd84, 8'd232, 8'd168, 8'd235, 8'd164, 8'd42, 8'd72, 8'd86, 8'd255
   };
   localparam logic [COLOR_W-1:0] BLUE [NUM_STOPS] = '{
      8'd92, 8'd196, 8'd255, 8'd74, 8'd60, 8'd32, 8'd24, 8'd42, 8'd178, 8'd255
   };

   // segment is named by its upper stop, 1..NUM_STOPS-1
   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [D_W-1:0]   d;
   } loc_word_type;

   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [T_W-1:0]   t;
   } frac_word_type;

endpackage

// ===== rtl/scr_locate.sv =====
// ----------------------------------------------------------------------------
// scr_locate
// Two stages: compare the sample against every stop, then pick the segment
// and the offset from its lower stop.
// ----------------------------------------------------------------------------
module scr_locate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [scr_pkg::H_W-1:0] in_height,
   output logic                          out_valid,
   input  logic                          out_ready,
   output scr_pkg::loc_word_type         out_word
);
   import scr_pkg::*;

   logic                    cmp_valid_ff;
   logic                    cmp_ready;
   logic signed [CMP_W-1:0] h_in;
   logic signed [CMP_W-1:0] h_ff;
   logic [NUM_STOPS-1:0]    le_in;
   logic [NUM_STOPS-1:0]    le_ff;

   logic                    loc_valid_ff;
   logic                    loc_ready;
   loc_word_type            loc_in;
   loc_word_type            loc_ff;
   logic signed [CMP_W-1:0] lower_pos;
   logic signed [CMP_W-1:0] offset;

   // stage 1: compares
   always_comb begin
      h_in = CMP_W'(in_height);
      for (int i = 0; i < NUM_STOPS; i++) begin
         le_in[i] = h_in <= $signed(CMP_W'(POS[i]));
      end
   end

   assign cmp_ready = !cmp_valid_ff || loc_ready;
   assign in_ready  = cmp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else if (cmp_ready) begin
         cmp_valid_ff <= in_valid;
      end
      if (cmp_ready && in_valid) begin
         h_ff  <= h_in;
         le_ff <= le_in;
      end
   end

   // stage 2: first stop at or above h; below the ramp maps to the lower end
   // of the first segment, above it to a saturating offset in the last
   always_comb begin
      loc_in.seg = SEG_W'(NUM_STOPS - 1);
      lower_pos  = '0;
      for (int i = NUM_STOPS - 1; i >= 1; i--) begin
         if (le_ff[i]) begin
            loc_in.seg = SEG_W'(i);
            lower_pos  = CMP_W'(POS[i-1]);
         end
      end
      offset = h_ff - lower_pos;
      if (le_ff[0]) begin
         loc_in.seg = SEG_W'(1);
         loc_in.d   = '0;
      end else if (!le_ff[NUM_STOPS-1]) begin
         loc_in.d   = '1;
      end else begin
         loc_in.d   = offset[D_W-1:0];
      end
   end

   assign loc_ready = !loc_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_valid_ff <= 1'b0;
      end else if (loc_ready) begin
         loc_valid_ff <= cmp_valid_ff;
      end
      if (loc_ready && cmp_valid_ff) begin
         loc_ff <= loc_in;
      end
   end

   assign out_valid = loc_valid_ff;
   assign out_word  = loc_ff;

endmodule

// ===== rtl/scr_fraction.sv =====
// ----------------------------------------------------------------------------
// scr_fraction
// Offset times segment reciprocal, saturated at 1.0 (32 fraction bits).
// ----------------------------------------------------------------------------
module scr_fraction (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  scr_pkg::loc_word_type  in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output scr_pkg::frac_word_type out_word
);
   import scr_pkg::*;

   localparam int PROD_W = D_W + RECIP_W;

   logic              valid_ff;
   logic [PROD_W-1:0] prod;
   frac_word_type     frac_in;
   frac_word_type     frac_ff;

   always_comb begin
      prod        = PROD_W'(in_word.d) * PROD_W'(RECIP[in_word.seg]);
      frac_in.seg = in_word.seg;
      if (prod > PROD_W'(T_FULL)) begin
         frac_in.t = T_FULL;
      end else begin
         frac_in.t = prod[T_W-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         frac_ff <= frac_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = frac_ff;

endmodule

// ===== rtl/scr_blend.sv =====
// ----------------------------------------------------------------------------
// scr_blend
// Per channel a + floor((b - a) * t / 2^32); the result register drives the
// output port.
// ----------------------------------------------------------------------------
module scr_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  scr_pkg::frac_word_type        in_word,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [scr_pkg::COLOR_W-1:0]   out_red,
   output logic [scr_pkg::COLOR_W-1:0]   out_green,
   output logic [scr_pkg::COLOR_W-1:0]   out_blue
);
   import scr_pkg::*;

   localparam int DIFF_W = COLOR_W + 1;
   localparam int MUL_W  = DIFF_W + T_W + 1;

   function automatic logic [COLOR_W-1:0] blend_ch(
      input logic [COLOR_W-1:0] a,
      input logic [COLOR_W-1:0] b,
      input logic [T_W-1:0]     t
   );
      logic signed [DIFF_W-1:0] diff;
      logic signed [MUL_W-1:0]  p;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      p    = diff * $signed({1'b0, t});
      // arithmetic shift floors; the sum stays in 0..255
      return a + p[RECIP_W +: COLOR_W];
   endfunction

   logic               valid_ff;
   logic [SEG_W-1:0]   lo;
   logic [COLOR_W-1:0] red_in, green_in, blue_in;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      lo       = in_word.seg - SEG_W'(1);
      red_in   = blend_ch(RED[lo],   RED[in_word.seg],   in_word.t);
      green_in = blend_ch(GREEN[lo], GREEN[in_word.seg], in_word.t);
      blue_in  = blend_ch(BLUE[lo],  BLUE[in_word.seg],  in_word.t);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

// ===== rtl/spectral_color_ramp.sv =====
// ----------------------------------------------------------------------------
// spectral_color_ramp
// Height sample to RGB pixel through a fixed ten-stop color ramp.
//
//   channel   ports                         word
//   -------   ---------------------------   --------------------------------
//   req       req_valid/req_ready           req_height, s18, 16 frac bits
//   rsp       rsp_valid/rsp_ready           rsp_red, rsp_green, rsp_blue, u8
//
// One word per clock sustained while rsp_ready stays high; four register stages
// (two locate stages, the reciprocal multiply, the blend multiply).
// Reset clears the stage valid bits only.
// Each stage loads when it is empty or its word moves on, so a rsp stall
// fills the bubbles first and then holds req_ready low; nothing is dropped.
// ----------------------------------------------------------------------------
`include "spectral_color_ramp_assert.svh"

module spectral_color_ramp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [scr_pkg::H_W-1:0] req_height,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [scr_pkg::COLOR_W-1:0]    rsp_red,
   output logic [scr_pkg::COLOR_W-1:0]    rsp_green,
   output logic [scr_pkg::COLOR_W-1:0]    rsp_blue
);
   import scr_pkg::*;

   logic          loc_valid;
   logic          loc_ready;
   loc_word_type  loc_word;
   logic          frac_valid;
   logic          frac_ready;
   frac_word_type frac_word;

   scr_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_height (req_height),
      .out_valid (loc_valid),
      .out_ready (loc_ready),
      .out_word  (loc_word)
   );

   scr_fraction u_fraction (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (loc_valid),
      .in_ready  (loc_ready),
      .in_word   (loc_word),
      .out_valid (frac_valid),
      .out_ready (frac_ready),
      .out_word  (frac_word)
   );

   scr_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frac_valid),
      .in_ready  (frac_ready),
      .in_word   (frac_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   `SCR_ASSERT(a_seg_range, clock, reset, loc_valid |-> (loc_word.seg >= SEG_W'(1) && loc_word.seg <= SEG_W'(NUM_STOPS - 1)))
   `SCR_ASSERT(a_t_sat, clock, reset, frac_valid |-> frac_word.t <= T_FULL)
   `SCR_ASSERT(a_loc_hold, clock, reset, loc_valid && !loc_ready |=> loc_valid && $stable(loc_word))
   `SCR_ASSERT(a_frac_hold, clock, reset, frac_valid && !frac_ready |=> frac_valid && $stable(frac_word))
   `SCR_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule
